// ===== design/sha1h_pkg.sv =====
// shared types and constants of the streaming sha-1 hasher
package sha1h_pkg;

    localparam int unsigned WordBits  = 32;
    localparam int unsigned BlockBits = 512;
    localparam int unsigned NumWords  = 5;

    localparam logic [6:0] LastRound = 7'd80;

    localparam logic [WordBits-1:0] Iv0 = 32'h67452301;
    localparam logic [WordBits-1:0] Iv1 = 32'hEFCDAB89;
    localparam logic [WordBits-1:0] Iv2 = 32'h98BADCFE;
    localparam logic [WordBits-1:0] Iv3 = 32'h10325476;
    localparam logic [WordBits-1:0] Iv4 = 32'hC3D2E1F0;

    localparam logic [WordBits-1:0] K0 = 32'h5A827999;
    localparam logic [WordBits-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WordBits-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WordBits-1:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PadMark = 8'h80;

    localparam logic       ActAbsorb = 1'b0;
    localparam logic       ActFinish = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef logic [NumWords-1:0][WordBits-1:0] t_chain;

    typedef struct packed {
        logic       shift;
        logic [7:0] shift_byte;
        logic       start;
        logic       iv_load;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

endpackage

// ===== design/sha1h_core.sv =====
// block window, message schedule and shared round unit of the sha-1 compression
module sha1h_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1h_pkg::t_core_ctl i_ctl,
    output sha1h_pkg::t_core_sts o_sts,
    output sha1h_pkg::t_chain    o_chain
);
    import sha1h_pkg::*;

    logic [BlockBits-1:0] r_win, n_win;
    logic [WordBits-1:0]  r_a, r_b, r_c, r_d, r_e;
    t_chain               r_h;
    logic [6:0]           r_round;
    logic                 r_busy;

    logic [WordBits-1:0] w_cur, w_mix, w_new, f, k, t;
    logic                in_round;

    always_comb begin
        w_cur = r_win[BlockBits-1 -: WordBits];
        w_mix = r_win[BlockBits-1-13*WordBits -: WordBits]
              ^ r_win[BlockBits-1-8*WordBits -: WordBits]
              ^ r_win[BlockBits-1-2*WordBits -: WordBits]
              ^ w_cur;
        w_new = {w_mix[WordBits-2:0], w_mix[WordBits-1]};
        if (r_round < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K0;
        end else if (r_round < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (r_round < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + w_cur;
        in_round = r_busy && (r_round != LastRound);
        if (i_ctl.shift) begin
            n_win = {r_win[BlockBits-9:0], i_ctl.shift_byte};
        end else if (in_round) begin
            n_win = {r_win[BlockBits-WordBits-1:0], w_new};
        end else begin
            n_win = r_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (in_round) begin
            r_a <= t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= {Iv4, Iv3, Iv2, Iv1, Iv0};
            r_busy  <= 1'b0;
            r_round <= '0;
        end else begin
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (in_round) begin
                r_round <= 7'(r_round + 7'd1);
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_ctl.iv_load) begin
                r_h <= {Iv4, Iv3, Iv2, Iv1, Iv0};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_round == LastRound);
    assign o_chain    = r_h;

endmodule

// ===== design/sha1_hasher_top.sv =====
// streaming sha-1 hasher: byte intake, padding sequencer and digest output
//
//  channel  dir  handshake                  payload
//  in       in   i_in_valid / o_in_ready    t_in_item  {action, data_byte}
//  out      out  o_out_valid / i_out_ready  t_out_item {digest_word, word_index, last_word}
//
// an absorb beat shifts its byte in; the 64th byte of a block starts compression
// on the single round unit (80 rounds, chaining add) and holds off the input
// a finish beat shifts in 64 - position pad bytes (plus 64 more when fewer
// than 9 bytes are free), one per cycle, each block followed by a compression
// the five digest beats follow, one per cycle while the sink is ready
// synchronous active-low reset restores the initial vector and empty state
module sha1_hasher_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sha1h_pkg::t_in_item i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sha1h_pkg::t_out_item o_out
);
    import sha1h_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ABS  = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_PADC = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [2:0] LastIdx = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_bits, n_bits;
    logic        r_first, n_first;
    logic        r_final, n_final;
    logic [2:0]  r_oidx, n_oidx;

    t_core_ctl ctl;
    t_core_sts sts;
    t_chain    chain;

    logic       in_fire;
    logic [2:0] len_sel;
    logic [7:0] len_byte, pad_byte;

    sha1h_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_chain (chain)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_fire     = i_in_valid && o_in_ready;

    assign len_sel  = ~r_pos[2:0];
    assign len_byte = r_bits[{len_sel, 3'b000} +: 8];

    always_comb begin
        if (r_first) begin
            pad_byte = PadMark;
        end else if (r_final && (r_pos >= 6'd56)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_bits  = r_bits;
        n_first = r_first;
        n_final = r_final;
        n_oidx  = r_oidx;
        ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.action == ActAbsorb) begin
                        ctl.shift      = 1'b1;
                        ctl.shift_byte = i_in.data_byte;
                        n_pos          = 6'(r_pos + 6'd1);
                        n_bits         = r_bits + 64'd8;
                        if (r_pos == 6'd63) begin
                            ctl.start = 1'b1;
                            n_state   = S_ABS;
                        end
                    end else begin
                        n_first = 1'b1;
                        n_final = (r_pos < 6'd56);
                        n_state = S_PAD;
                    end
                end
            end
            S_ABS: begin
                if (sts.done) begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                ctl.shift      = 1'b1;
                ctl.shift_byte = pad_byte;
                n_first        = 1'b0;
                n_pos          = 6'(r_pos + 6'd1);
                if (r_pos == 6'd63) begin
                    ctl.start = 1'b1;
                    n_state   = S_PADC;
                end
            end
            S_PADC: begin
                if (sts.done) begin
                    if (r_final) begin
                        n_oidx  = '0;
                        n_state = S_OUT;
                    end else begin
                        n_final = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_oidx == LastIdx) begin
                        ctl.iv_load = 1'b1;
                        n_bits      = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_oidx = 3'(r_oidx + 3'd1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_bits  <= '0;
            r_first <= 1'b0;
            r_final <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bits  <= n_bits;
            r_first <= n_first;
            r_final <= n_final;
            r_oidx  <= n_oidx;
        end
    end

    assign o_out.digest_word = chain[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == LastIdx);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |-> !sts.busy)
        else $error("compression started while round unit busy");

    a_out_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pos == 6'd0) && !sts.busy)
        else $error("digest shown with partial block pending");

    a_last_back_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.last_word) |=> o_in_ready && (r_bits == 64'd0))
        else $error("block not back to empty state after last digest beat");

    a_shift_no_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.shift |-> !sts.busy)
        else $error("byte shifted into window during compression");

endmodule
